>>> rtl/sti_pkg.sv
// Package: widths, constants and miss codes for the segment/triangle tester.
`timescale 1ns / 1ps
package sti_pkg;
  localparam int unsigned CoordBitsDef = 21;
  localparam int unsigned SlotBits     = 21;
  localparam int unsigned PointBits    = 3 * SlotBits;
  localparam int unsigned ThrBits      = 32;
  localparam logic [ThrBits-1:0] ThrReset = 32'd1;

  typedef enum logic [2:0] {
    MISS_NONE     = 3'd0,
    MISS_PARALLEL = 3'd1,
    MISS_U        = 3'd2,
    MISS_V        = 3'd3,
    MISS_T        = 3'd4
  } miss_e;

  typedef struct packed {
    logic   hit;
    miss_e  reason;
  } result_t;
endpackage

>>> rtl/sti_vec.sv
// Vector stage: unpacks points, forms difference vectors and cross products.
`timescale 1ns / 1ps
module sti_vec #(
  parameter int unsigned CoordBits = sti_pkg::CoordBitsDef
) (
  input  logic                           clk_i,
  input  logic                           en_i,
  input  logic [sti_pkg::PointBits-1:0]  seg_start_i,
  input  logic [sti_pkg::PointBits-1:0]  seg_end_i,
  input  logic [sti_pkg::PointBits-1:0]  vert_a_i,
  input  logic [sti_pkg::PointBits-1:0]  vert_b_i,
  input  logic [sti_pkg::PointBits-1:0]  vert_c_i,
  output logic signed [CoordBits:0]      dir_o [3],
  output logic signed [CoordBits:0]      e1_o [3],
  output logic signed [CoordBits:0]      e2_o [3],
  output logic signed [CoordBits:0]      tv_o [3],
  output logic signed [2*CoordBits+2:0]  pv_o [3],
  output logic signed [2*CoordBits+2:0]  qv_o [3]
);
  localparam int unsigned DW = CoordBits + 1;
  localparam int unsigned PW = 2 * DW;

  logic signed [DW-1:0] dir_q [3], e1_q [3], e2_q [3], tv_q [3];
  logic signed [PW-1:0] m1_q [3], m2_q [3];
  logic signed [DW-1:0] dir_s [3], e1_s [3], e2_s [3], tv_s [3];
  logic signed [PW:0]   pv_q [3], qv_q [3];

  function automatic logic signed [DW-1:0] crd(input logic [sti_pkg::PointBits-1:0] f,
                                               input int unsigned k);
    logic signed [CoordBits-1:0] c;
    c = f[k*sti_pkg::SlotBits +: CoordBits];
    return DW'(c);
  endfunction

  // stage 1: differences
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < 3; k++) begin
        dir_q[k] <= crd(seg_end_i, k) - crd(seg_start_i, k);
        e1_q[k]  <= crd(vert_b_i, k) - crd(vert_a_i, k);
        e2_q[k]  <= crd(vert_c_i, k) - crd(vert_a_i, k);
        tv_q[k]  <= crd(seg_start_i, k) - crd(vert_a_i, k);
      end
    end
  end

  // stage 2: cross-product terms, one multiply per register
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < 3; k++) begin
        m1_q[k] <= dir_q[(k+1)%3] * e2_q[(k+2)%3];
        m2_q[k] <= dir_q[(k+2)%3] * e2_q[(k+1)%3];
        dir_s[k] <= dir_q[k];
        e1_s[k]  <= e1_q[k];
        e2_s[k]  <= e2_q[k];
        tv_s[k]  <= tv_q[k];
      end
    end
  end

  logic signed [PW-1:0] n1_q [3], n2_q [3];
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < 3; k++) begin
        n1_q[k] <= tv_q[(k+1)%3] * e1_q[(k+2)%3];
        n2_q[k] <= tv_q[(k+2)%3] * e1_q[(k+1)%3];
      end
    end
  end

  // stage 3: subtract
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < 3; k++) begin
        pv_q[k] <= (PW+1)'(m1_q[k]) - (PW+1)'(m2_q[k]);
        qv_q[k] <= (PW+1)'(n1_q[k]) - (PW+1)'(n2_q[k]);
        dir_o[k] <= dir_s[k];
        e1_o[k]  <= e1_s[k];
        e2_o[k]  <= e2_s[k];
        tv_o[k]  <= tv_s[k];
      end
    end
  end

  assign pv_o = pv_q;
  assign qv_o = qv_q;
endmodule

>>> rtl/sti_dot.sv
// Dot stage: det, un, vn, tn as exact dot products, then sign folding.
`timescale 1ns / 1ps
module sti_dot #(
  parameter int unsigned CoordBits = sti_pkg::CoordBitsDef
) (
  input  logic                           clk_i,
  input  logic                           en_i,
  input  logic signed [CoordBits:0]      dir_i [3],
  input  logic signed [CoordBits:0]      e1_i [3],
  input  logic signed [CoordBits:0]      e2_i [3],
  input  logic signed [CoordBits:0]      tv_i [3],
  input  logic signed [2*CoordBits+2:0]  pv_i [3],
  input  logic signed [2*CoordBits+2:0]  qv_i [3],
  output logic signed [3*CoordBits+6:0]  det_o,
  output logic signed [3*CoordBits+6:0]  un_o,
  output logic signed [3*CoordBits+6:0]  vn_o,
  output logic signed [3*CoordBits+6:0]  tn_o
);
  localparam int unsigned DW = CoordBits + 1;
  localparam int unsigned PW = 2 * DW + 1;
  localparam int unsigned MW = DW + PW;
  localparam int unsigned SW = MW + 3;
  localparam int unsigned HW = (PW + 1) / 2;   // split pv/qv to keep multipliers narrow
  localparam int unsigned LW = PW - HW;

  // stage 1: partial products, upper signed half and lower unsigned half
  logic signed [DW+HW-1:0] ph_q [4][3];
  logic signed [DW+LW:0]   pl_q [4][3];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < 3; k++) begin
        ph_q[0][k] <= e1_i[k]  * $signed(pv_i[k][PW-1:LW]);
        pl_q[0][k] <= e1_i[k]  * $signed({1'b0, pv_i[k][LW-1:0]});
        ph_q[1][k] <= tv_i[k]  * $signed(pv_i[k][PW-1:LW]);
        pl_q[1][k] <= tv_i[k]  * $signed({1'b0, pv_i[k][LW-1:0]});
        ph_q[2][k] <= dir_i[k] * $signed(qv_i[k][PW-1:LW]);
        pl_q[2][k] <= dir_i[k] * $signed({1'b0, qv_i[k][LW-1:0]});
        ph_q[3][k] <= e2_i[k]  * $signed(qv_i[k][PW-1:LW]);
        pl_q[3][k] <= e2_i[k]  * $signed({1'b0, qv_i[k][LW-1:0]});
      end
    end
  end

  // stage 2: recombine each product
  logic signed [MW-1:0] pr_q [4][3];
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int j = 0; j < 4; j++) begin
        for (int k = 0; k < 3; k++) begin
          pr_q[j][k] <= (MW'(ph_q[j][k]) <<< LW) + MW'(pl_q[j][k]);
        end
      end
    end
  end

  // stage 3: sum the three terms
  logic signed [SW-1:0] s_q [4];
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int j = 0; j < 4; j++) begin
        s_q[j] <= SW'(pr_q[j][0]) + SW'(pr_q[j][1]) + SW'(pr_q[j][2]);
      end
    end
  end

  // stage 4: fold sign of det into all four
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (s_q[0][SW-1]) begin
        det_o <= -s_q[0];
        un_o  <= -s_q[1];
        vn_o  <= -s_q[2];
        tn_o  <= -s_q[3];
      end else begin
        det_o <= s_q[0];
        un_o  <= s_q[1];
        vn_o  <= s_q[2];
        tn_o  <= s_q[3];
      end
    end
  end
endmodule

>>> rtl/sti_judge.sv
// Judge stage: range tests against det and miss reason selection.
`timescale 1ns / 1ps
module sti_judge #(
  parameter int unsigned CoordBits = sti_pkg::CoordBitsDef
) (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  logic [sti_pkg::ThrBits-1:0]   thr_i,
  input  logic signed [3*CoordBits+6:0] det_i,
  input  logic signed [3*CoordBits+6:0] un_i,
  input  logic signed [3*CoordBits+6:0] vn_i,
  input  logic signed [3*CoordBits+6:0] tn_i,
  output sti_pkg::result_t              res_o
);
  localparam int unsigned SW = 3 * CoordBits + 7;

  typedef struct packed {
    logic par, u_bad, v_bad, t_bad;
  } flags_t;

  flags_t f_q;
  logic signed [SW:0] uv;

  assign uv = (SW+1)'(un_i) + (SW+1)'(vn_i);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      f_q.par   <= (SW+1)'(det_i) < $signed({{(SW+1-sti_pkg::ThrBits){1'b0}}, thr_i});
      f_q.u_bad <= un_i[SW-1] || (un_i > det_i);
      f_q.v_bad <= vn_i[SW-1] || (uv > (SW+1)'(det_i));
      f_q.t_bad <= tn_i[SW-1] || (tn_i > det_i);
    end
  end

  sti_pkg::result_t res_d;
  always_comb begin
    res_d.hit = 1'b0;
    priority if (f_q.par)   res_d.reason = sti_pkg::MISS_PARALLEL;
    else if (f_q.u_bad)     res_d.reason = sti_pkg::MISS_U;
    else if (f_q.v_bad)     res_d.reason = sti_pkg::MISS_V;
    else if (f_q.t_bad)     res_d.reason = sti_pkg::MISS_T;
    else begin
      res_d.reason = sti_pkg::MISS_NONE;
      res_d.hit    = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_o <= res_d;
    end
  end
endmodule

>>> rtl/segment_triangle_intersect_core.sv
// Segment versus triangle crossing test (Moller-Trumbore), deeply pipelined.
// Use: an input transfer on the s_axis group carries the segment start and end
// and the three triangle vertices, each point being three 21-bit coordinate
// slots. The m_axis group returns one result per input: hit and a miss reason
// (0 hit, 1 parallel, 2 u outside, 3 v or u+v outside, 4 t outside).
// parallel_threshold sits at APB address 0 (reset value 1); write it only when
// the pipe is empty.
// Pipeline: 9 register stages, none of which advances while stalled.
// Throughput: one pair per clock when not stalled; each of the 9 register
// stages carries a valid bit and at most one multiply per path.
// Stall: when m_axis_tready is low with a result waiting, the whole pipe holds
// and s_axis_tready drops.
// Reset: rst_ni clears all valid bits and reloads the threshold.
`timescale 1ns / 1ps
module segment_triangle_intersect_core #(
  parameter int unsigned CoordBits = sti_pkg::CoordBitsDef
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // seg_start[62:0], seg_end[125:63], vert_a[188:126], vert_b[251:189],
  // vert_c[314:252], zero fill
  input  logic [319:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // hit[0], miss_reason[3:1], zero fill
  output logic [7:0]   m_axis_tdata,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [1:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);
  localparam int unsigned Depth = 9;
  localparam int unsigned PB = sti_pkg::PointBits;
  localparam int unsigned SW = 3 * CoordBits + 7;

  logic [sti_pkg::ThrBits-1:0] thr_q;
  logic [Depth-1:0] vld_q;
  logic en;

  assign pready = 1'b1;
  assign prdata = (paddr == 2'd0) ? thr_q : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= sti_pkg::ThrReset;
    end else if (psel && penable && pwrite && paddr == 2'd0) begin
      thr_q <= pwdata;
    end
  end

  // whole-pipe enable: advance unless the output holds a result not taken
  assign en = !(vld_q[Depth-1] && !m_axis_tready);
  assign s_axis_tready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[Depth-2:0], s_axis_tvalid};
    end
  end

  logic signed [CoordBits:0]     dir [3], e1 [3], e2 [3], tv [3];
  logic signed [2*CoordBits+2:0] pv [3], qv [3];
  logic signed [SW-1:0]          det, un, vn, tn;
  sti_pkg::result_t              res;

  sti_vec #(.CoordBits(CoordBits)) u_vec (
    .clk_i, .en_i(en),
    .seg_start_i(s_axis_tdata[0*PB +: PB]),
    .seg_end_i  (s_axis_tdata[1*PB +: PB]),
    .vert_a_i   (s_axis_tdata[2*PB +: PB]),
    .vert_b_i   (s_axis_tdata[3*PB +: PB]),
    .vert_c_i   (s_axis_tdata[4*PB +: PB]),
    .dir_o(dir), .e1_o(e1), .e2_o(e2), .tv_o(tv), .pv_o(pv), .qv_o(qv)
  );

  sti_dot #(.CoordBits(CoordBits)) u_dot (
    .clk_i, .en_i(en),
    .dir_i(dir), .e1_i(e1), .e2_i(e2), .tv_i(tv), .pv_i(pv), .qv_i(qv),
    .det_o(det), .un_o(un), .vn_o(vn), .tn_o(tn)
  );

  sti_judge #(.CoordBits(CoordBits)) u_judge (
    .clk_i, .en_i(en), .thr_i(thr_q),
    .det_i(det), .un_i(un), .vn_i(vn), .tn_i(tn), .res_o(res)
  );

  assign m_axis_tvalid = vld_q[Depth-1];
  assign m_axis_tdata  = {4'd0, res.reason, res.hit};

`ifndef SYNTHESIS
  a_hit_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (res.hit == (res.reason == sti_pkg::MISS_NONE)))
    else $error("hit flag disagrees with miss reason");
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("result changed under stall");
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input blocked with empty output");
`endif
endmodule
